### design/contiguous_first_fit_block_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
`ifndef CONTIGUOUS_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CFFBA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("allocator check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CFFBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define CFFBA_ASSERT_SAME(label, clk, rstn, ante, cons)
`define CFFBA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

### design/cffba_pkg.sv
`default_nettype none

package cffba_pkg;

    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD      = 2'd2;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [LEN_W-1:0] run;
    } tok_t;

    // Broadcast write of a range of used bits.
    typedef struct packed {
        logic vld;
        logic val;
    } upd_t;

endpackage

`default_nettype wire

### design/cffba_cell.sv
`default_nettype none

module cffba_cell #(
    parameter int INDEX = 1,
    parameter int IW    = 7,
    parameter int AW    = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cffba_pkg::tok_t             tok_in,
    input  wire logic [IW-1:0]               start_in,
    input  wire logic [cffba_pkg::LEN_W-1:0] len,
    input  wire cffba_pkg::upd_t             upd,
    input  wire logic [AW-1:0]               upd_lo,
    input  wire logic [AW-1:0]               upd_hi,
    output cffba_pkg::tok_t                  tok_out,
    output logic [IW-1:0]                    start_out
);

    localparam logic [AW-1:0] MY_IDX = AW'(INDEX);

    logic                        used_reg;
    logic                        used_next;
    cffba_pkg::tok_t             tok_reg;
    cffba_pkg::tok_t             tok_next;
    logic [IW-1:0]               start_reg;
    logic [IW-1:0]               start_next;
    logic [cffba_pkg::LEN_W-1:0] run_inc;

    assign run_inc = tok_in.run + cffba_pkg::LEN_W'(1);

    always_comb begin
        tok_next   = tok_in;
        start_next = start_in;
        if (tok_in.vld && !tok_in.found) begin
            if (used_reg) begin
                tok_next.run = '0;
            end else begin
                tok_next.run = run_inc;
                if (run_inc == len) begin
                    tok_next.found = 1'b1;
                    // run ends here: start = index - len + 1
                    start_next = IW'(INDEX + 1) - IW'(len);
                end
            end
        end
    end

    always_comb begin
        used_next = used_reg;
        if (upd.vld && (MY_IDX >= upd_lo) && (MY_IDX <= upd_hi)) begin
            used_next = upd.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= 1'b0;
            tok_reg.vld <= 1'b0;
        end else begin
            used_reg    <= used_next;
            tok_reg.vld <= tok_next.vld;
        end
        tok_reg.found <= tok_next.found;
        tok_reg.run   <= tok_next.run;
        start_reg     <= start_next;
    end

    assign tok_out   = tok_reg;
    assign start_out = start_reg;

endmodule

`default_nettype wire

### design/contiguous_first_fit_block_allocator.sv
// First-fit contiguous block allocator. One used bit per block lives in a row of
// BLOCK_COUNT-1 cells (block 0, the superblock, is never allocated). A free, or any
// request with a bad length or range, skips the search and goes straight to the done
// state. An allocate sends a search token down the cell row one block per cycle; its
// result is taken when the token leaves the last cell.
// One request is worked on at a time; a new one is taken while an earlier result still
// waits on the m_ side. granted_start carries the low 7 bits of the start block.
`default_nettype none
`include "contiguous_first_fit_block_allocator_macros.svh"

module contiguous_first_fit_block_allocator #(
    parameter int BLOCK_COUNT = 128
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [cffba_pkg::LEN_W-1:0]    s_run_start,
    input  wire logic [cffba_pkg::LEN_W-1:0]    s_run_length,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [cffba_pkg::STATUS_W-1:0]      m_status,
    output logic [cffba_pkg::LEN_W-1:0]         m_granted_start
);

    localparam int IW = $clog2(BLOCK_COUNT);
    localparam int AW = ((IW > cffba_pkg::LEN_W) ? IW : cffba_pkg::LEN_W) + 1;
    localparam logic [AW-1:0] LAST_BLOCK = AW'(BLOCK_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [cffba_pkg::LEN_W-1:0]     len_reg, len_next;
    cffba_pkg::tok_t                 inj_reg, inj_next;
    cffba_pkg::upd_t                 upd_reg, upd_next;
    logic [AW-1:0]                   lo_reg, lo_next;
    logic [AW-1:0]                   hi_reg, hi_next;
    logic [cffba_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [cffba_pkg::LEN_W-1:0]     res_start_reg, res_start_next;
    logic                            m_valid_reg, m_valid_next;
    logic [cffba_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [cffba_pkg::LEN_W-1:0]     m_granted_reg, m_granted_next;

    cffba_pkg::tok_t                 tok_chain   [BLOCK_COUNT];
    logic [IW-1:0]                   start_chain [BLOCK_COUNT];

    logic [AW-1:0]                   free_hi;
    logic [AW-1:0]                   found_start;
    cffba_pkg::tok_t                 tok_end;

    assign tok_chain[0]   = inj_reg;
    assign start_chain[0] = '0;
    assign tok_end        = tok_chain[BLOCK_COUNT-1];

    genvar gi;
    generate
        for (gi = 1; gi < BLOCK_COUNT; gi++) begin : g_cell
            cffba_cell #(
                .INDEX (gi),
                .IW    (IW),
                .AW    (AW)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .tok_in    (tok_chain[gi-1]),
                .start_in  (start_chain[gi-1]),
                .len       (len_reg),
                .upd       (upd_reg),
                .upd_lo    (lo_reg),
                .upd_hi    (hi_reg),
                .tok_out   (tok_chain[gi]),
                .start_out (start_chain[gi])
            );
        end
    endgenerate

    assign s_ready     = (state_reg == S_IDLE);
    assign free_hi     = AW'(s_run_start) + AW'(s_run_length) - AW'(1);
    assign found_start = AW'(start_chain[BLOCK_COUNT-1]);

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        inj_next        = inj_reg;
        inj_next.vld    = 1'b0;
        upd_next        = upd_reg;
        upd_next.vld    = 1'b0;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_granted_next  = m_granted_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    len_next       = s_run_length;
                    res_start_next = '0;
                    state_next     = S_DONE;
                    if (s_run_length == '0) begin
                        res_status_next = cffba_pkg::ST_BAD;
                    end else if (s_cmd == cffba_pkg::CMD_ALLOC) begin
                        inj_next.vld   = 1'b1;
                        inj_next.found = 1'b0;
                        inj_next.run   = '0;
                        state_next     = S_SCAN;
                    end else if (free_hi > LAST_BLOCK) begin
                        res_status_next = cffba_pkg::ST_BAD;
                    end else begin
                        upd_next.vld    = 1'b1;
                        upd_next.val    = 1'b0;
                        lo_next         = AW'(s_run_start);
                        hi_next         = free_hi;
                        res_status_next = cffba_pkg::ST_OK;
                    end
                end
            end
            S_SCAN: begin
                // wait for the token to leave the last cell
                if (tok_end.vld) begin
                    state_next = S_DONE;
                    if (tok_end.found) begin
                        upd_next.vld    = 1'b1;
                        upd_next.val    = 1'b1;
                        lo_next         = found_start;
                        hi_next         = found_start + AW'(len_reg) - AW'(1);
                        res_status_next = cffba_pkg::ST_OK;
                        res_start_next  = found_start[cffba_pkg::LEN_W-1:0];
                    end else begin
                        res_status_next = cffba_pkg::ST_NO_SPACE;
                        res_start_next  = '0;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_start_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            inj_reg.vld <= 1'b0;
            upd_reg.vld <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inj_reg.vld <= inj_next.vld;
            upd_reg.vld <= upd_next.vld;
            m_valid_reg <= m_valid_next;
        end
        len_reg        <= len_next;
        inj_reg.found  <= inj_next.found;
        inj_reg.run    <= inj_next.run;
        upd_reg.val    <= upd_next.val;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        m_status_reg   <= m_status_next;
        m_granted_reg  <= m_granted_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_start = m_granted_reg;

    `CFFBA_ASSERT_SAME(a_upd_in_done, aclk, aresetn, upd_reg.vld, state_reg == S_DONE)
    `CFFBA_ASSERT_SAME(a_inj_in_scan, aclk, aresetn, inj_reg.vld, state_reg == S_SCAN)
    `CFFBA_ASSERT_SAME(a_tok_in_scan, aclk, aresetn, tok_end.vld, state_reg == S_SCAN)
    `CFFBA_ASSERT_SAME(a_alloc_range, aclk, aresetn, upd_reg.vld && upd_reg.val,
        (lo_reg != '0) && (lo_reg <= hi_reg) && (hi_reg <= LAST_BLOCK))
    `CFFBA_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg != S_IDLE)

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCKS       = 128;
    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_ITEMS   = 100;
    localparam int PRESSURE_AT  = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = BLOCKS + 16;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic                        cmd;
        logic [cffba_pkg::LEN_W-1:0] start;
        logic [cffba_pkg::LEN_W-1:0] len;
    } request_t;

    typedef struct packed {
        logic [cffba_pkg::STATUS_W-1:0] status;
        logic [cffba_pkg::LEN_W-1:0]    granted;
    } grant_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic                           s_cmd        = cffba_pkg::CMD_ALLOC;
    logic [cffba_pkg::LEN_W-1:0]    s_run_start  = '0;
    logic [cffba_pkg::LEN_W-1:0]    s_run_length = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [cffba_pkg::STATUS_W-1:0] m_status;
    logic [cffba_pkg::LEN_W-1:0]    m_granted_start;

    request_t pending_requests[$];
    grant_t   expected_grants[$];

    // Used maps: one follows accepted items, one is the plan the generator works from.
    logic [BLOCKS-1:0]           used_blocks   = '0;
    logic [BLOCKS-1:0]           planned_used  = '0;
    logic [cffba_pkg::LEN_W-1:0] live_start[$];
    logic [cffba_pkg::LEN_W-1:0] live_len[$];

    int accepted_count = 0;
    int tail_from      = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int send_idle      = 0;
    int recv_stall     = 0;
    int recv_hold      = 0;
    bit pressure_done  = 1'b0;

    contiguous_first_fit_block_allocator #(
        .BLOCK_COUNT(BLOCKS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_run_start    (s_run_start),
        .s_run_length   (s_run_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_granted_start(m_granted_start)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // First-fit allocate or range free on a used map; block 0 never gets set.
    function automatic void allocate_or_free(inout logic [BLOCKS-1:0] map,
                                             input logic cmd,
                                             input logic [cffba_pkg::LEN_W-1:0] start,
                                             input logic [cffba_pkg::LEN_W-1:0] len,
                                             output logic [cffba_pkg::STATUS_W-1:0] status,
                                             output logic [cffba_pkg::LEN_W-1:0] granted);
        int run;
        int found;
        int last;
        status  = cffba_pkg::ST_OK;
        granted = '0;
        if (len == 0) begin
            status = cffba_pkg::ST_BAD;
        end else if (cmd == cffba_pkg::CMD_ALLOC) begin
            run   = 0;
            found = 0;
            for (int b = 1; b < BLOCKS; b++) begin
                if (found == 0) begin
                    if (map[b]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == int'(len)) found = b - int'(len) + 1;
                    end
                end
            end
            if (found == 0) begin
                status = cffba_pkg::ST_NO_SPACE;
            end else begin
                for (int b = found; b < found + int'(len); b++) map[b] = 1'b1;
                granted = found[cffba_pkg::LEN_W-1:0];
            end
        end else begin
            last = int'(start) + int'(len) - 1;
            if (last > BLOCKS - 1) begin
                status = cffba_pkg::ST_BAD;
            end else begin
                for (int b = int'(start); b <= last; b++) map[b] = 1'b0;
                map[0] = 1'b0;
            end
        end
    endfunction

    task automatic plan(input logic cmd, input logic [cffba_pkg::LEN_W-1:0] start,
                        input logic [cffba_pkg::LEN_W-1:0] len);
        request_t                       req;
        logic [cffba_pkg::STATUS_W-1:0] st;
        logic [cffba_pkg::LEN_W-1:0]    g;
        req.cmd   = cmd;
        req.start = start;
        req.len   = len;
        allocate_or_free(planned_used, cmd, start, len, st, g);
        pending_requests.push_back(req);
        if (cmd == cffba_pkg::CMD_ALLOC && st == cffba_pkg::ST_OK) begin
            live_start.push_back(g);
            live_len.push_back(len);
        end
    endtask

    task automatic plan_random_item();
        int r;
        int idx;
        int s;
        int l;
        int off;
        int c;
        r = $urandom_range(0, 99);
        if (r < 80 && r >= 45 && live_start.size() != 0) begin
            // Release a live run, whole or a slice of it.
            idx = $urandom_range(0, live_start.size() - 1);
            s   = int'(live_start[idx]);
            l   = int'(live_len[idx]);
            live_start.delete(idx);
            live_len.delete(idx);
            if ($urandom_range(0, 3) == 0) begin
                off = $urandom_range(0, l - 1);
                l   = $urandom_range(1, l - off);
                s   = s + off;
            end
            plan(cffba_pkg::CMD_FREE, s[cffba_pkg::LEN_W-1:0], l[cffba_pkg::LEN_W-1:0]);
        end else if (r < 80) begin
            r = $urandom_range(0, 99);
            if (r < 70)      l = $urandom_range(1, 8);
            else if (r < 90) l = $urandom_range(9, 40);
            else             l = $urandom_range(41, 127);
            s = $urandom_range(0, 127);
            plan(cffba_pkg::CMD_ALLOC, s[cffba_pkg::LEN_W-1:0], l[cffba_pkg::LEN_W-1:0]);
        end else if (r < 83) begin
            plan(cffba_pkg::CMD_FREE, 7'd1, 7'd127);
            live_start.delete();
            live_len.delete();
        end else begin
            c = $urandom_range(0, 1);
            s = $urandom_range(0, 127);
            l = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 127);
            plan(c[0], s[cffba_pkg::LEN_W-1:0], l[cffba_pkg::LEN_W-1:0]);
        end
    endtask

    initial begin
        // Directed: bad lengths, whole-disk allocate, range ends, holes.
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd0);
        plan(cffba_pkg::CMD_FREE,  7'd5,   7'd0);
        plan(cffba_pkg::CMD_ALLOC, 7'd127, 7'd127);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd1);
        plan(cffba_pkg::CMD_FREE,  7'd0,   7'd127);
        plan(cffba_pkg::CMD_FREE,  7'd127, 7'd1);
        plan(cffba_pkg::CMD_FREE,  7'd127, 7'd2);
        plan(cffba_pkg::CMD_FREE,  7'd1,   7'd127);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd10);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd20);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd5);
        plan(cffba_pkg::CMD_FREE,  7'd11,  7'd20);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd25);
        plan(cffba_pkg::CMD_ALLOC, 7'd85,  7'd20);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd127);
        plan(cffba_pkg::CMD_FREE,  7'd100, 7'd28);
        plan(cffba_pkg::CMD_FREE,  7'd100, 7'd29);
        plan(cffba_pkg::CMD_FREE,  7'd64,  7'd64);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd64);
        plan(cffba_pkg::CMD_FREE,  7'd0,   7'd1);
        plan(cffba_pkg::CMD_FREE,  7'd1,   7'd127);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd126);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd2);
        plan(cffba_pkg::CMD_ALLOC, 7'd0,   7'd1);
        plan(cffba_pkg::CMD_FREE,  7'd1,   7'd127);
        live_start.delete();
        live_len.delete();

        repeat (RANDOM_ITEMS) plan_random_item();
        tail_from = pending_requests.size() - TAIL_ITEMS;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid) @(posedge aclk);
        while (expected_grants.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_grants.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Driver: predict on each accepted item, then present the next or idle.
    always @(posedge aclk) begin
        request_t            req;
        logic [BLOCKS-1:0]   map;
        grant_t              exp_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                map = used_blocks;
                allocate_or_free(map, s_cmd, s_run_start, s_run_length,
                                 exp_item.status, exp_item.granted);
                used_blocks = map;
                expected_grants.push_back(exp_item);
                accepted_count++;
                if (accepted_count < tail_from && $urandom_range(0, 3) == 0)
                    send_idle = $urandom_range(1, 7);
            end
            if (!s_valid || s_ready) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    req = pending_requests.pop_front();
                    s_cmd        <= req.cmd;
                    s_run_start  <= req.start;
                    s_run_length <= req.len;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness: random stalls plus one long hold-off to back up the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!pressure_done && accepted_count >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                recv_hold     = HOLD_CYCLES;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (accepted_count < tail_from && $urandom_range(0, 5) == 0)
                    recv_stall = $urandom_range(1, 7);
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        grant_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected item: status %0d granted_start %0d",
                       m_status, m_granted_start);
                mismatches++;
            end else begin
                exp_item = expected_grants.pop_front();
                if (m_status !== exp_item.status) begin
                    $error("status: expected %0d, actual %0d", exp_item.status, m_status);
                    mismatches++;
                end
                if (m_granted_start !== exp_item.granted) begin
                    $error("granted_start: expected %0d, actual %0d",
                           exp_item.granted, m_granted_start);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

`default_nettype wire
